/* src/edd_pkg.sv */
`timescale 1ns / 1ps

package edd_pkg;

	// default row store depth
	localparam int MAX_WIDTH_DEF = 1024;

	// field and register widths
	localparam int PIX_W     = 8;
	localparam int WIDTH_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int ERR_W     = 14;

	// iterative divider: dividend and divisor width, quotient bits per cycle
	localparam int DIV_W         = 12;
	localparam int DIV_STEP_BITS = 3;
	localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

	// register reset values
	localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [PIX_W-1:0]   MAX_RST    = 8'd255;
	localparam logic [PIX_W-1:0]   LEVELS_RST = 8'd2;

	// diffusion weights in sixteenths
	localparam logic [3:0] W_RIGHT      = 4'd7;
	localparam logic [3:0] W_DOWN_LEFT  = 4'd3;
	localparam logic [3:0] W_DOWN       = 4'd5;
	localparam logic [3:0] W_DOWN_RIGHT = 4'd1;

	// saturation bounds of a stored error
	localparam logic signed [15:0] ERR_MAX = 16'sd8191;
	localparam logic signed [15:0] ERR_MIN = -16'sd8192;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 2'd0,
		CFG_MAX_VALUE   = 2'd1,
		CFG_LEVELS      = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SUM,
		ST_QUOT,
		ST_ERR,
		ST_WB,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step_load;
		logic sum_en;
		logic quant_en;
		logic err_en;
		logic wb_en;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

	// clip a sum to the stored error range
	function automatic err_t sat_err(input logic signed [15:0] x);
		if (x > ERR_MAX) begin
			return err_t'(ERR_MAX);
		end else if (x < ERR_MIN) begin
			return err_t'(ERR_MIN);
		end
		return err_t'(x);
	endfunction

	// w*e/16 rounded to nearest, ties upward
	function automatic err_t share(input logic [3:0] w, input err_t e);
		logic signed [17:0] x;
		x = 18'(e) * $signed({14'd0, w}) + 18'sd8;
		return err_t'(x >>> 4);
	endfunction

endpackage

/* src/edd_ram.sv */
`timescale 1ns / 1ps

module edd_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/edd_div.sv */
`timescale 1ns / 1ps

module edd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [edd_pkg::DIV_W-1:0]  dividend,
	input  logic [edd_pkg::DIV_W-1:0]  divisor,
	output logic                       done,
	output logic [edd_pkg::DIV_W-1:0]  quotient,
	output logic [edd_pkg::DIV_W-1:0]  remainder
);

	localparam int W = edd_pkg::DIV_W;
	localparam logic [edd_pkg::DIV_CNT_W-1:0] CNT_LAST =
		edd_pkg::DIV_CNT_W'(edd_pkg::DIV_CYCLES - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [edd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [W-1:0]                  num_q;
	logic [W-1:0]                  dvs_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  rem_q;

	logic [W-1:0] num_n;
	logic [W-1:0] quo_n;
	logic [W-1:0] rem_n;

	// a few restoring steps per cycle
	always_comb begin
		logic [W:0]   r;
		logic [W-1:0] n;
		logic [W-1:0] q;
		r = {1'b0, rem_q};
		n = num_q;
		q = quo_q;
		for (int i = 0; i < edd_pkg::DIV_STEP_BITS; i++) begin
			r = {r[W-1:0], n[W-1]};
			n = {n[W-2:0], 1'b0};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
				q = {q[W-2:0], 1'b1};
			end else begin
				q = {q[W-2:0], 1'b0};
			end
		end
		num_n = n;
		quo_n = q;
		rem_n = r[W-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (busy_q) begin
				cnt_q <= cnt_q + edd_pkg::DIV_CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* src/edd_datapath.sv */
`timescale 1ns / 1ps

module edd_datapath #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [edd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edd_pkg::WIDTH_W-1:0]     cfg_data,
	input  logic [edd_pkg::PIX_W-1:0]       pixel,
	input  logic                            frame_start,
	input  logic                            out_stall,
	input  edd_pkg::cmd_t                   cmd,
	output edd_pkg::status_t                status,
	output logic                            out_valid,
	output logic [edd_pkg::PIX_W-1:0]       dithered,
	output logic                            row_last
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int FILL_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W  = (COL_W + 1 > edd_pkg::WIDTH_W) ? COL_W + 1 : edd_pkg::WIDTH_W;
	localparam int PW     = edd_pkg::PIX_W;
	localparam int DW     = edd_pkg::DIV_W;
	localparam int EW     = edd_pkg::ERR_W;

	// configuration
	logic [edd_pkg::WIDTH_W-1:0] width_q;
	logic [PW-1:0]               max_q;
	logic [PW-1:0]               levels_q;

	// carried state
	edd_pkg::err_t    right_q;
	edd_pkg::err_t    diag_q;
	edd_pkg::err_t    pend_q;
	edd_pkg::err_t    wbprev_q;
	logic [COL_W-1:0] column_q;
	logic             first_q;
	logic [FILL_W-1:0] fill_q;

	// per pixel working registers
	logic [PW-1:0]    pixel_q;
	logic [COL_W-1:0] c_q;
	logic             last_q;
	logic [PW-1:0]    step_q;
	logic [DW-1:0]    v16_q;
	edd_pkg::err_t    e_q;
	logic [PW-1:0]    dith_q;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] out_dith_q;
	logic          out_last_q;

	// effective configuration
	logic [PW-1:0]    mx_eff;
	logic [PW-1:0]    lvm1;
	logic [CMP_W-1:0] w_eff;
	logic [COL_W-1:0] c_eff;

	always_comb begin
		logic [PW:0]      lv9;
		logic [PW:0]      lim;
		logic [CMP_W-1:0] wext;
		mx_eff = (max_q == '0) ? PW'(1) : max_q;
		lv9 = {1'b0, levels_q};
		if (lv9 < (PW + 1)'(2)) begin
			lv9 = (PW + 1)'(2);
		end
		lim = {1'b0, mx_eff} + (PW + 1)'(1);
		if (lv9 > lim) begin
			lv9 = lim;
		end
		lvm1 = PW'(lv9 - (PW + 1)'(1));
		wext = CMP_W'(width_q);
		if (wext == '0) begin
			w_eff = CMP_W'(1);
		end else if (wext > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = wext;
		end
		c_eff = frame_start ? '0 : column_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= edd_pkg::WIDTH_RST;
			max_q    <= edd_pkg::MAX_RST;
			levels_q <= edd_pkg::LEVELS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				edd_pkg::CFG_IMAGE_WIDTH: width_q  <= cfg_data;
				edd_pkg::CFG_MAX_VALUE:   max_q    <= cfg_data[PW-1:0];
				edd_pkg::CFG_LEVELS:      levels_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// row error store and its read path
	logic [EW-1:0]    ram_rdata;
	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic [EW-1:0]    ram_wdata;

	edd_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (c_eff),
		.rdata (ram_rdata)
	);

	// carried error, clamp to 0..max_value in sixteenths
	logic [DW-1:0] v16_c;

	always_comb begin
		edd_pkg::err_t       st;
		logic signed [EW:0]  carried;
		logic signed [15:0]  v_sum;
		logic [DW-1:0]       mx16;
		st = (!first_q && (FILL_W'(c_q) < fill_q)) ? $signed(ram_rdata) : '0;
		carried = (EW + 1)'(right_q) + (EW + 1)'(st);
		v_sum = $signed({4'd0, pixel_q, 4'd0}) + 16'(carried);
		mx16 = {mx_eff, 4'd0};
		if (v_sum < 16'sd0) begin
			v16_c = '0;
		end else if (v_sum > $signed({4'd0, mx16})) begin
			v16_c = mx16;
		end else begin
			v16_c = v_sum[DW-1:0];
		end
	end

	// shared divider: level step first, then level index
	logic          div_start;
	logic [DW-1:0] div_dvd;
	logic [DW-1:0] div_dvs;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	assign div_start = cmd.accept | cmd.sum_en;
	assign div_dvd   = cmd.sum_en ? v16_c : DW'(mx_eff);
	assign div_dvs   = cmd.sum_en ? {step_q, 4'd0} : DW'(lvm1);

	edd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// nearest level, ties to the lower one, and the residual error
	logic [PW-1:0]  k_fin;
	logic [15:0]    prod;
	edd_pkg::err_t  e_c;

	always_comb begin
		logic [DW-1:0] step16;
		step16 = {step_q, 4'd0};
		if (div_quo >= DW'(lvm1)) begin
			k_fin = lvm1;
		end else if ({div_rem, 1'b0} > {1'b0, step16}) begin
			k_fin = div_quo[PW-1:0] + PW'(1);
		end else begin
			k_fin = div_quo[PW-1:0];
		end
		prod = 16'(k_fin) * 16'(step_q);
		e_c = $signed({2'd0, v16_q}) - $signed({2'd0, prod[PW-1:0], 4'd0});
	end

	// error shares
	edd_pkg::err_t s_right;
	edd_pkg::err_t s_dleft;
	edd_pkg::err_t s_down;
	edd_pkg::err_t s_dright;
	edd_pkg::err_t down_val;

	always_comb begin
		s_right  = edd_pkg::share(edd_pkg::W_RIGHT, e_q);
		s_dleft  = edd_pkg::share(edd_pkg::W_DOWN_LEFT, e_q);
		s_down   = edd_pkg::share(edd_pkg::W_DOWN, e_q);
		s_dright = edd_pkg::share(edd_pkg::W_DOWN_RIGHT, e_q);
		down_val = edd_pkg::sat_err(16'(diag_q) + 16'(s_down));
	end

	// store writes: this column, then the column to the left
	always_comb begin
		ram_we    = cmd.err_en | (cmd.wb_en & (c_q != '0));
		ram_waddr = cmd.err_en ? c_q : c_q - COL_W'(1);
		ram_wdata = cmd.err_en ? down_val : wbprev_q;
	end

	// per pixel working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pixel_q <= pixel;
			c_q     <= c_eff;
			last_q  <= CMP_W'(c_eff) >= (w_eff - CMP_W'(1));
		end
		if (cmd.step_load) begin
			step_q <= div_quo[PW-1:0];
		end
		if (cmd.sum_en) begin
			v16_q <= v16_c;
		end
		if (cmd.quant_en) begin
			e_q    <= e_c;
			dith_q <= prod[PW-1:0];
		end
		if (cmd.err_en) begin
			pend_q   <= down_val;
			wbprev_q <= edd_pkg::sat_err(16'(pend_q) + 16'(s_dleft));
		end
	end

	// carried row state and store fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q  <= '0;
			diag_q   <= '0;
			column_q <= '0;
			first_q  <= 1'b1;
			fill_q   <= '0;
		end else begin
			if (cmd.accept && frame_start) begin
				right_q  <= '0;
				diag_q   <= '0;
				column_q <= '0;
				first_q  <= 1'b1;
			end
			if (cmd.err_en) begin
				if (last_q) begin
					right_q  <= '0;
					diag_q   <= '0;
					column_q <= '0;
					first_q  <= 1'b0;
				end else begin
					right_q  <= s_right;
					diag_q   <= s_dright;
					column_q <= c_q + COL_W'(1);
				end
			end
			if (ram_we && (FILL_W'(ram_waddr) >= fill_q)) begin
				fill_q <= FILL_W'(ram_waddr) + FILL_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_dith_q <= dith_q;
			out_last_q <= last_q;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign dithered  = out_dith_q;
	assign row_last  = out_last_q;

endmodule

/* src/edd_ctrl.sv */
`timescale 1ns / 1ps

module edd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  edd_pkg::status_t status,
	output logic             in_stall,
	output edd_pkg::cmd_t    cmd
);

	edd_pkg::state_t state_q;
	edd_pkg::state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edd_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// sequence of one pixel
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			edd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = edd_pkg::ST_STEP;
				end
			end
			edd_pkg::ST_STEP: begin
				if (status.div_done) begin
					cmd.step_load = 1'b1;
					state_n       = edd_pkg::ST_SUM;
				end
			end
			edd_pkg::ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_n    = edd_pkg::ST_QUOT;
			end
			edd_pkg::ST_QUOT: begin
				if (status.div_done) begin
					cmd.quant_en = 1'b1;
					state_n      = edd_pkg::ST_ERR;
				end
			end
			edd_pkg::ST_ERR: begin
				cmd.err_en = 1'b1;
				state_n    = edd_pkg::ST_WB;
			end
			edd_pkg::ST_WB: begin
				cmd.wb_en = 1'b1;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = edd_pkg::ST_IDLE;
				end else begin
					state_n = edd_pkg::ST_FIN;
				end
			end
			edd_pkg::ST_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = edd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = edd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* src/error_diffusion_dither.sv */
`timescale 1ns / 1ps

// Multilevel Floyd-Steinberg error-diffusion dither. Grey pixels enter in
// raster order on the valid/stall input channel, frame_start marking the first
// pixel of an image, and each gives one dithered pixel with row_last set at
// the end of its row. One pixel is in work at a time and goes through these
// steps in order: a first pass through a shared divider that retires three
// quotient bits per cycle (level step), the addition of the carried error read
// from the row store, a second divider pass (level index), quantization, and
// two writes to the row store, which has a single write port. A finished result
// waits in an output register while the next pixel is taken. The row store
// needs no clearing pass after reset: a fill count marks the columns written
// so far and the others read as zero. Register writes (image_width, max_value,
// levels) are taken at any cycle but belong between pixels.
module error_diffusion_dither #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [edd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [edd_pkg::WIDTH_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [edd_pkg::PIX_W-1:0]     pixel,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [edd_pkg::PIX_W-1:0]     dithered,
	output logic                          row_last
);

	edd_pkg::cmd_t    cmd;
	edd_pkg::status_t status;

	edd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	edd_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel),
		.frame_start (frame_start),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.dithered    (dithered),
		.row_last    (row_last)
	);

endmodule

/* src/edd_checker.sv */
`timescale 1ns / 1ps

module edd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [edd_pkg::PIX_W-1:0]     dithered,
	input logic                          row_last
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dithered) && $stable(row_last))
		else $error("result changed while stalled");

	// one pixel in work: input stays stalled after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while a pixel is in work");

	// no result appears right after an input transaction
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too early");

	// reset leaves the block ready and empty
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("block not idle in reset");

endmodule

bind error_diffusion_dither edd_checker u_chk (.*);
